>>> src/space_vector_pwm_duty_assert.svh
// Assertion macros for the SVPWM duty block.
// Both macros expect clk_i and rst_ni in scope.
`ifndef SPACE_VECTOR_PWM_DUTY_ASSERT_SVH
`define SPACE_VECTOR_PWM_DUTY_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SVPWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SVPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Types, constants and register indexes shared by the SVPWM duty block.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // voltage fraction bits (Q2.14)
  localparam int unsigned VOLT_FRAC_BITS = 14;
  // product of two Q2.14 values carries twice the fraction bits
  localparam int unsigned PROD_FRAC_BITS = 2 * VOLT_FRAC_BITS;

  // 1/sqrt3 and 2/sqrt3 rounded to VOLT_FRAC_BITS fraction bits
  localparam logic signed [15:0] K_INV_SQRT3     = 16'sd9459;
  localparam logic signed [15:0] K_TWO_INV_SQRT3 = 16'sd18919;

  // max_modulation saturates at 1.0 in Q1.15
  localparam logic [15:0] MOD_ONE = 16'd32768;

  localparam logic [15:0] PERIOD_RST  = 16'd4096;
  localparam logic [15:0] MAX_MOD_RST = 16'd32768;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MOD    = 2'd1;

  // hexagon sector codes
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;
  localparam logic [2:0] SECTOR_6 = 3'd6;

  typedef struct packed {
    logic signed [15:0] v_alpha;
    logic signed [15:0] v_beta;
  } in_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector;
  } out_t;

  // live configuration seen by the datapath
  typedef struct packed {
    logic [15:0] period;
    logic [15:0] tmax;
  } cfg_t;

endpackage

>>> src/space_vector_pwm_duty.sv
// ----------------------------------------------------------------------------
// space_vector_pwm_duty
// Space vector PWM: alpha/beta voltage vector to three phase compare values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one (v_alpha, v_beta) beat
//   in signed Q2.14. Output channel out_valid_o / out_stall_i carries the
//   three compare values and the sector 1..6 for that beat, in input order.
//   Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 = pwm_period, 1 = max_modulation); other indexes are ignored.
//   Write config only while no beat is in flight.
// Timing:
//   Six register stages: an accepted beat moves through stages 1 to 6 and is
//   on the output from the stage 6 register. One beat per cycle is sustained
//   while out_stall_i is low; each stage holds at most one beat, and the 32x17
//   on-time multipliers set the stage depth.
// Reset:
//   All stages empty; pwm_period = 4096, max_modulation = 1.0.
// Stall:
//   A stalled output holds its beat; stages behind it keep filling bubbles,
//   and in_stall_o rises only once every stage holds a beat.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty
  import svpwm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i
);

  `include "space_vector_pwm_duty_assert.svh"

  function automatic logic [15:0] clamp_duty(input logic signed [23:0] d,
                                             input logic [15:0] tmax);
    logic signed [23:0] lim;
    lim = $signed({8'd0, tmax});
    if (d[23]) begin
      return 16'd0;
    end else if (d > lim) begin
      return tmax;
    end else begin
      return d[15:0];
    end
  endfunction

  cfg_t cfg;

  svpwm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // ---------------- stage flow control ----------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  always_comb begin
    en6 = !v6_q || !out_stall_i;
    en5 = !v5_q || en6;
    en4 = !v4_q || en5;
    en3 = !v3_q || en4;
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
  end

  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // ---------------- stage 1: scale alpha, beta/sqrt3, 2*beta/sqrt3 ----------------
  logic signed [29:0] a1_q, a1_d;
  logic signed [29:0] s1_q, s1_d;
  logic signed [30:0] t1_q, t1_d;

  always_comb begin
    a1_d = {in_data_i.v_alpha, {VOLT_FRAC_BITS{1'b0}}};
    s1_d = 30'(in_data_i.v_beta) * 30'(K_INV_SQRT3);
    t1_d = 31'(in_data_i.v_beta) * 31'(K_TWO_INV_SQRT3);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      a1_q <= a1_d;
      s1_q <= s1_d;
      t1_q <= t1_d;
    end
  end

  // ---------------- stage 2: sector and on-time fractions ----------------
  logic signed [31:0] ae, se, te, nse;
  logic signed [31:0] fx2_d, fy2_d, fx2_q, fy2_q;
  logic [2:0]         sec2_d, sec2_q;

  always_comb begin
    ae  = 32'(a1_q);
    se  = 32'(s1_q);
    te  = 32'(t1_q);
    nse = -se;
    // sign of beta is the sign of beta/sqrt3
    if (!s1_q[29]) begin
      if (!a1_q[29]) sec2_d = (se > ae) ? SECTOR_2 : SECTOR_1;
      else           sec2_d = (nse > ae) ? SECTOR_3 : SECTOR_2;
    end else begin
      if (!a1_q[29]) sec2_d = (nse > ae) ? SECTOR_5 : SECTOR_6;
      else           sec2_d = (se > ae) ? SECTOR_4 : SECTOR_5;
    end
    unique case (sec2_d)
      SECTOR_1: begin fx2_d = ae - se;  fy2_d = te;       end
      SECTOR_2: begin fx2_d = ae + se;  fy2_d = se - ae;  end
      SECTOR_3: begin fx2_d = te;       fy2_d = nse - ae; end
      SECTOR_4: begin fx2_d = se - ae;  fy2_d = -te;      end
      SECTOR_5: begin fx2_d = nse - ae; fy2_d = ae - se;  end
      default:  begin fx2_d = -te;      fy2_d = ae + se;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      fx2_q  <= fx2_d;
      fy2_q  <= fy2_d;
      sec2_q <= sec2_d;
    end
  end

  // ---------------- stage 3: fraction times period ----------------
  logic signed [16:0] per_s;
  logic signed [48:0] px3_q, py3_q;
  logic [2:0]         sec3_q;

  assign per_s = $signed({1'b0, cfg.period});

  always_ff @(posedge clk_i) begin
    if (en3) begin
      px3_q  <= 49'(fx2_q) * 49'(per_s);
      py3_q  <= 49'(fy2_q) * 49'(per_s);
      sec3_q <= sec2_q;
    end
  end

  // ---------------- stage 4: truncate toward zero, order on-times ----------------
  logic signed [48:0] bias_x, bias_y, qx, qy;
  logic signed [19:0] x4, y4, u4_q, w4_q;
  logic [2:0]         sec4_q;
  logic               even4;

  always_comb begin
    bias_x = px3_q[48] ? 49'sd268435455 : 49'sd0;
    bias_y = py3_q[48] ? 49'sd268435455 : 49'sd0;
    qx     = (px3_q + bias_x) >>> PROD_FRAC_BITS;
    qy     = (py3_q + bias_y) >>> PROD_FRAC_BITS;
    x4     = qx[19:0];
    y4     = qy[19:0];
    // even sectors subtract the second on-time first
    even4  = (sec3_q == SECTOR_2) || (sec3_q == SECTOR_4) || (sec3_q == SECTOR_6);
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      u4_q   <= even4 ? y4 : x4;
      w4_q   <= even4 ? x4 : y4;
      sec4_q <= sec3_q;
    end
  end

  // ---------------- stage 5: center value ----------------
  logic signed [21:0] sum5, sum5_adj, half5;
  logic signed [21:0] neg5;
  logic signed [20:0] d05_q;
  logic signed [19:0] u5_q, w5_q;
  logic [2:0]         sec5_q;

  always_comb begin
    sum5     = $signed({6'd0, cfg.period}) + 22'(u4_q) + 22'(w4_q);
    neg5     = $signed({21'd0, sum5[21]});
    sum5_adj = sum5 + neg5;
    half5    = sum5_adj >>> 1;
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      d05_q  <= half5[20:0];
      u5_q   <= u4_q;
      w5_q   <= w4_q;
      sec5_q <= sec4_q;
    end
  end

  // ---------------- stage 6: differences, clamp, route ----------------
  logic signed [23:0] d0, d1, d2;
  logic [15:0]        c0, c1, c2;
  out_t               out_d, out_q;

  always_comb begin
    d0 = 24'(d05_q);
    d1 = d0 - 24'(u5_q);
    d2 = d1 - 24'(w5_q);
    c0 = clamp_duty(d0, cfg.tmax);
    c1 = clamp_duty(d1, cfg.tmax);
    c2 = clamp_duty(d2, cfg.tmax);
    out_d.sector = sec5_q;
    unique case (sec5_q)
      SECTOR_1: begin out_d.duty_a = c0; out_d.duty_b = c1; out_d.duty_c = c2; end
      SECTOR_2: begin out_d.duty_a = c1; out_d.duty_b = c0; out_d.duty_c = c2; end
      SECTOR_3: begin out_d.duty_a = c2; out_d.duty_b = c0; out_d.duty_c = c1; end
      SECTOR_4: begin out_d.duty_a = c2; out_d.duty_b = c1; out_d.duty_c = c0; end
      SECTOR_5: begin out_d.duty_a = c1; out_d.duty_b = c2; out_d.duty_c = c0; end
      default:  begin out_d.duty_a = c0; out_d.duty_b = c2; out_d.duty_c = c1; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v6_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  `SVPWM_ASSERT_NOW(a_sector_range, out_valid_o,
    (out_data_o.sector >= SECTOR_1) && (out_data_o.sector <= SECTOR_6),
    "sector outside 1..6")
  `SVPWM_ASSERT_NOW(a_duty_limit, out_valid_o,
    (out_data_o.duty_a <= cfg.tmax) && (out_data_o.duty_b <= cfg.tmax) &&
    (out_data_o.duty_c <= cfg.tmax),
    "duty above clamp limit")
  `SVPWM_ASSERT_NOW(a_stall_full, in_stall_o,
    out_valid_o && out_stall_i && v1_q && v5_q,
    "input stalled with room in the pipeline")
  `SVPWM_ASSERT_NEXT(a_tmax_period, 1'b1,
    cfg.tmax <= $past(cfg.period),
    "clamp limit above period")

endmodule

>>> src/svpwm_cfg.sv
// ----------------------------------------------------------------------------
// svpwm_cfg
// Configuration registers and the registered duty clamp limit.
// ----------------------------------------------------------------------------
module svpwm_cfg
  import svpwm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  output cfg_t                 cfg_o
);

  logic [15:0] period_q;
  logic [15:0] max_mod_q;
  logic [15:0] tmax_q, tmax_d;
  logic [15:0] mod_sat;
  logic [16:0] mod_sum;
  logic [32:0] lim_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q  <= PERIOD_RST;
      max_mod_q <= MAX_MOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PWM_PERIOD: period_q  <= cfg_wdata_i;
        REG_MAX_MOD:    max_mod_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // tmax = period * (1 + mod) / 2, mod in Q1.15
  always_comb begin
    mod_sat  = (max_mod_q > MOD_ONE) ? MOD_ONE : max_mod_q;
    mod_sum  = 17'(MOD_ONE) + 17'(mod_sat);
    lim_prod = 33'(period_q) * 33'(mod_sum);
    tmax_d   = lim_prod[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmax_q <= PERIOD_RST;
    end else begin
      tmax_q <= tmax_d;
    end
  end

  assign cfg_o.period = period_q;
  assign cfg_o.tmax   = tmax_q;

endmodule
